/* hw/rtl/unicycle_pose_predictor_core_assert.svh */
// Assertion macros of the pose predictor checker.
`ifndef UNICYCLE_POSE_PREDICTOR_CORE_ASSERT_SVH
`define UNICYCLE_POSE_PREDICTOR_CORE_ASSERT_SVH

// Concurrent assertion on a full property, disabled while reset is low.
`define UPP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion: the consequent must hold in the cycle after the antecedent.
`define UPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/upp_pkg.sv */
// Shared constants, types and tables of the unicycle pose predictor.
`default_nettype none

package upp_pkg;

  // CORDIC depth and arctangent table size
  localparam int unsigned CordicStages = 16;
  localparam int unsigned AtanEntries  = 30;
  localparam int unsigned CordicIters  =
      (CordicStages < AtanEntries) ? CordicStages : AtanEntries;

  // Field widths
  localparam int unsigned PoseW    = 32;
  localparam int unsigned TsW      = 16;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned InDataW  = 5 * PoseW;
  localparam int unsigned OutDataW = 3 * PoseW;

  // Q16.16 to Q2.30 widening and the modulo reduction word
  localparam int unsigned Q30Shift = 14;
  localparam int unsigned ModW     = PoseW + Q30Shift;
  // highest multiple 2*pi * 2^k that a widened heading can reach
  localparam int unsigned ModTopK  = 12;

  // Angle and CORDIC vector widths
  localparam int unsigned AngW  = 34;
  localparam int unsigned CordW = 34;
  localparam int unsigned MulAW = PoseW + CordW;
  localparam int unsigned MulBOpW = MulAW - 30;
  localparam int unsigned MulBW = MulBOpW + TsW + 1;

  localparam logic [TsW-1:0] TimeStepReset = 16'd3277;

  localparam logic signed [PoseW:0] PiQ16    = 33'sd205887;
  localparam logic signed [PoseW:0] TwoPiQ16 = 33'sd411775;

  localparam logic [ModW-1:0]        TwoPiQ30Mod = 46'd6746518852;
  localparam logic signed [AngW-1:0] TwoPiQ30    = 34'sd6746518852;
  localparam logic signed [AngW-1:0] PiQ30       = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30   = 34'sd1686629713;
  localparam logic signed [CordW-1:0] GainQ30    = 34'sd652032874;

  // Arctangent of 2^-i in Q2.30
  function automatic logic signed [AngW-1:0] atan_q30(input logic [IdxW-1:0] idx);
    logic signed [AngW-1:0] val;
    unique case (idx)
      5'd0:    val = 34'sd843314857;
      5'd1:    val = 34'sd497837829;
      5'd2:    val = 34'sd263043837;
      5'd3:    val = 34'sd133525159;
      5'd4:    val = 34'sd67021687;
      5'd5:    val = 34'sd33543516;
      5'd6:    val = 34'sd16775851;
      5'd7:    val = 34'sd8388437;
      5'd8:    val = 34'sd4194283;
      5'd9:    val = 34'sd2097149;
      5'd10:   val = 34'sd1048576;
      5'd11:   val = 34'sd524288;
      5'd12:   val = 34'sd262144;
      5'd13:   val = 34'sd131072;
      5'd14:   val = 34'sd65536;
      5'd15:   val = 34'sd32768;
      5'd16:   val = 34'sd16384;
      5'd17:   val = 34'sd8192;
      5'd18:   val = 34'sd4096;
      5'd19:   val = 34'sd2048;
      5'd20:   val = 34'sd1024;
      5'd21:   val = 34'sd512;
      5'd22:   val = 34'sd256;
      5'd23:   val = 34'sd128;
      5'd24:   val = 34'sd64;
      5'd25:   val = 34'sd32;
      5'd26:   val = 34'sd16;
      5'd27:   val = 34'sd8;
      5'd28:   val = 34'sd4;
      5'd29:   val = 34'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_MOD,
    ST_RANGE,
    ST_FOLD,
    ST_CORDIC,
    ST_NEG,
    ST_MUL_C,
    ST_MUL_S,
    ST_MUL_Y,
    ST_UPDATE,
    ST_EMIT
  } upp_state_e;

  // Datapath commands
  typedef struct packed {
    logic            capture;
    logic            abs_load;
    logic            mod_step;
    logic            range;
    logic            fold;
    logic            cordic_step;
    logic            negate;
    logic            mul_cos;
    logic            mul_sin;
    logic            mul_y;
    logic            update;
    logic            emit;
    logic [IdxW-1:0] idx;
  } upp_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/upp_ctrl.sv */
// Sequencer of the pose predictor: state machine, step counter, output valid.
`default_nettype none

module upp_ctrl
  import upp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_load_i,
  output logic          in_ready_o,
  input  wire logic     out_ready_i,
  output logic          out_valid_o,
  output upp_cmd_t      cmd_o
);

  upp_state_e      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_load_i ? ST_EMIT : ST_ABS;
        end
      end
      ST_ABS: begin
        state_d = ST_MOD;
        cnt_d   = IdxW'(ModTopK);
      end
      ST_MOD: begin
        if (cnt_q == '0) begin
          state_d = ST_RANGE;
        end else begin
          cnt_d = cnt_q - IdxW'(1);
        end
      end
      ST_RANGE: state_d = ST_FOLD;
      ST_FOLD: begin
        state_d = ST_CORDIC;
        cnt_d   = '0;
      end
      ST_CORDIC: begin
        if (cnt_q == IdxW'(CordicIters - 1)) begin
          state_d = ST_NEG;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      ST_NEG:    state_d = ST_MUL_C;
      ST_MUL_C:  state_d = ST_MUL_S;
      ST_MUL_S:  state_d = ST_MUL_Y;
      ST_MUL_Y:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd_o             = '0;
    cmd_o.idx         = cnt_q;
    in_ready_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_ABS:    cmd_o.abs_load    = 1'b1;
      ST_MOD:    cmd_o.mod_step    = 1'b1;
      ST_RANGE:  cmd_o.range       = 1'b1;
      ST_FOLD:   cmd_o.fold        = 1'b1;
      ST_CORDIC: cmd_o.cordic_step = 1'b1;
      ST_NEG:    cmd_o.negate      = 1'b1;
      ST_MUL_C:  cmd_o.mul_cos     = 1'b1;
      ST_MUL_S:  cmd_o.mul_sin     = 1'b1;
      ST_MUL_Y:  cmd_o.mul_y       = 1'b1;
      ST_UPDATE: cmd_o.update      = 1'b1;
      ST_EMIT:   cmd_o.emit        = slot_free;
      default:   cmd_o.emit        = 1'b0;
    endcase
  end

  // Output slot: set on emit, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/upp_dp.sv */
// Datapath of the pose predictor: pose state, angle reduction, CORDIC, products.
`default_nettype none

module upp_dp
  import upp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TsW-1:0]      cfg_wdata_i,
  input  wire upp_cmd_t            cmd_i,
  input  wire logic                in_load_i,
  input  wire logic                in_last_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_last_o
);

  logic [TsW-1:0]          ts_q;
  logic [PoseW-1:0]        pose_x_q, pose_y_q, pose_h_q;
  logic signed [PoseW-1:0] v_q, w_q, hw_q;
  logic                    last_q;
  logic [ModW-1:0]         m_q;
  logic                    neg_q, flip_q;
  logic signed [AngW-1:0]  a_q, z_q;
  logic signed [CordW-1:0] x_q, y_q;
  logic signed [MulAW-1:0] pa_q;
  logic [PoseW-1:0]        dx_q, dy_q, dh_q;
  logic [PoseW-1:0]        out_x_q, out_y_q, out_h_q;
  logic                    out_last_q;

  // Heading wrap, once each way
  logic signed [PoseW:0] h_ext, h_wrap;
  always_comb begin
    h_ext = {pose_h_q[PoseW-1], pose_h_q};
    if (h_ext > PiQ16) begin
      h_wrap = h_ext - TwoPiQ16;
    end else if (h_ext < -PiQ16) begin
      h_wrap = h_ext + TwoPiQ16;
    end else begin
      h_wrap = h_ext;
    end
  end

  // Magnitude of the wrapped heading
  logic signed [PoseW:0] hw_ext, hw_mag;
  assign hw_ext = {hw_q[PoseW-1], hw_q};
  assign hw_mag = hw_q[PoseW-1] ? -hw_ext : hw_ext;

  // Restoring reduction by 2*pi * 2^k
  logic [ModW-1:0] mod_sub;
  logic            mod_ge;
  assign mod_sub = TwoPiQ30Mod << cmd_i.idx;
  assign mod_ge  = m_q >= mod_sub;

  // Signed remainder brought into [-pi, pi]
  logic signed [AngW-1:0] mm, md, r_wrap;
  logic                   m_gt;
  always_comb begin
    mm   = signed'(m_q[AngW-1:0]);
    md   = mm - TwoPiQ30;
    m_gt = mm > PiQ30;
    if (neg_q) begin
      r_wrap = m_gt ? -md : -mm;
    end else begin
      r_wrap = m_gt ? md : mm;
    end
  end

  // Fold into [-pi/2, pi/2]
  logic signed [AngW-1:0] z_fold;
  logic                   fold_flip;
  always_comb begin
    fold_flip = 1'b1;
    if (a_q > HalfPiQ30) begin
      z_fold = a_q - PiQ30;
    end else if (a_q < -HalfPiQ30) begin
      z_fold = a_q + PiQ30;
    end else begin
      z_fold    = a_q;
      fold_flip = 1'b0;
    end
  end

  // One CORDIC rotation
  logic signed [CordW-1:0] xs, ys;
  logic signed [AngW-1:0]  atan_v;
  assign xs     = x_q >>> cmd_i.idx;
  assign ys     = y_q >>> cmd_i.idx;
  assign atan_v = atan_q30(cmd_i.idx);

  // Speed times trig value, then scaled by the time step; turn rate scaled by the time step
  logic signed [CordW-1:0]   trig;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBOpW-1:0] opb;
  logic signed [TsW:0]       ts_s;
  logic signed [MulBW-1:0]   mul_b;
  logic [PoseW-1:0]          mul_b_sh;
  assign trig     = cmd_i.mul_cos ? x_q : y_q;
  assign mul_a    = v_q * trig;
  assign opb      = cmd_i.mul_cos ? MulBOpW'(w_q) : pa_q[MulAW-1:MulAW-MulBOpW];
  assign ts_s     = signed'({1'b0, ts_q});
  assign mul_b    = opb * ts_s;
  assign mul_b_sh = mul_b[PoseW+TsW-1:TsW];

  // Time step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TimeStepReset;
    end else if (cfg_we_i) begin
      ts_q <= cfg_wdata_i;
    end
  end

  // Pose state: load or Euler update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q <= '0;
      pose_y_q <= '0;
      pose_h_q <= '0;
    end else if (cmd_i.capture && in_load_i) begin
      pose_x_q <= in_data_i[PoseW-1:0];
      pose_y_q <= in_data_i[2*PoseW-1:PoseW];
      pose_h_q <= in_data_i[3*PoseW-1:2*PoseW];
    end else if (cmd_i.update) begin
      pose_x_q <= pose_x_q + dx_q;
      pose_y_q <= pose_y_q + dy_q;
      pose_h_q <= hw_q + dh_q;
    end
  end

  // Working registers of one step
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q    <= signed'(in_data_i[4*PoseW-1:3*PoseW]);
      w_q    <= signed'(in_data_i[5*PoseW-1:4*PoseW]);
      last_q <= in_last_i;
      hw_q   <= h_wrap[PoseW-1:0];
    end
    if (cmd_i.abs_load) begin
      m_q   <= {hw_mag[PoseW-1:0], {Q30Shift{1'b0}}};
      neg_q <= hw_q[PoseW-1];
    end
    if (cmd_i.mod_step && mod_ge) begin
      m_q <= m_q - mod_sub;
    end
    if (cmd_i.range) begin
      a_q <= r_wrap;
    end
    if (cmd_i.fold) begin
      z_q    <= z_fold;
      flip_q <= fold_flip;
      x_q    <= GainQ30;
      y_q    <= '0;
    end
    if (cmd_i.cordic_step) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.negate && flip_q) begin
      x_q <= -x_q;
      y_q <= -y_q;
    end
    if (cmd_i.mul_cos) begin
      pa_q <= mul_a;
      dh_q <= mul_b_sh;
    end
    if (cmd_i.mul_sin) begin
      pa_q <= mul_a;
      dx_q <= mul_b_sh;
    end
    if (cmd_i.mul_y) begin
      dy_q <= mul_b_sh;
    end
    if (cmd_i.emit) begin
      out_x_q    <= pose_x_q;
      out_y_q    <= pose_y_q;
      out_h_q    <= pose_h_q;
      out_last_q <= last_q;
    end
  end

  assign out_data_o = {out_h_q, out_y_q, out_x_q};
  assign out_last_o = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/unicycle_pose_predictor_core.sv */
// Top level of the unicycle pose predictor: sequencer plus datapath.
//
// Input stream: one transfer per item. tuser high loads the pose from the
// init fields and echoes it; tuser low applies one speed/turn-rate command
// with forward-Euler integration over time_step. tlast travels to the result.
// Output stream: one result per item, the new pose, with the same tlast.
// Load items go from capture straight to the emit step. Command items pass
// through the absolute-value step, a radix-2 reduction of the heading by
// 2*pi, range wrap and fold steps, one CORDIC rotation per cycle on the
// shared shift-add unit, a sign step, then the two multipliers and the pose adders.
// The next item is taken in the cycle after its predecessor enters the
// output register, so a result may wait for the receiver while the next
// item is already being worked on; a stalled receiver only holds the
// sequencer in its emit step once a second result is ready.
// Reset clears the pose to zero, sets time_step to 3277 and empties the
// output register. The user writes the time step through cfg_we_i/cfg_wdata_i
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module unicycle_pose_predictor_core
  import upp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TsW-1:0]      cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // init_x, init_y, init_heading, speed_cmd, turn_cmd
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // load
  input  wire logic                s_axis_tuser_i,
  input  wire logic                s_axis_tlast_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // pred_x, pred_y, pred_heading
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tlast_o
);

  upp_cmd_t cmd;

  // Sequencer
  upp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_load_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  // Datapath
  upp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .in_load_i   (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .in_data_i   (s_axis_tdata_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/upp_checker.sv */
// Port-level checker of the pose predictor and its bind to the top level.
`default_nettype none

`include "unicycle_pose_predictor_core_assert.svh"

module upp_checker
  import upp_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [InDataW-1:0]  s_axis_tdata_i,
  input wire logic                s_axis_tuser_i,
  input wire logic                s_axis_tlast_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o,
  input wire logic                m_axis_tlast_o
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // Hold a stalled result
  `UPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
      m_axis_tvalid_o && !m_axis_tready_i,
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o),
      "result changed while stalled")

  // One item at a time: busy right after an input transfer
  `UPP_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, !s_axis_tready_o,
      "input taken while an item is in flight")

  // A load into an empty output slot echoes the pose after the emit step
  `UPP_ASSERT(a_load_echo, clk_i, rst_ni,
      (in_xfer && s_axis_tuser_i && !m_axis_tvalid_o) |-> ##2 (m_axis_tvalid_o &&
      (m_axis_tdata_o == $past(s_axis_tdata_i[OutDataW-1:0], 2)) &&
      (m_axis_tlast_o == $past(s_axis_tlast_i, 2))),
      "load not echoed")

  // A new result appears only out of a busy step
  `UPP_ASSERT(a_emit_busy, clk_i, rst_ni,
      $rose(m_axis_tvalid_o) |-> ($past(s_axis_tready_o) == 1'b0),
      "result appeared while idle")

endmodule

bind unicycle_pose_predictor_core upp_checker u_upp_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the unicycle pose predictor core.
`timescale 1ns / 100ps

module testbench;
  import upp_pkg::*;

  // Fixed-point constants of the pose integrator
  localparam longint PI_FIX16       = 205887;
  localparam longint TWO_PI_FIX16   = 411775;
  localparam longint PI_FIX30       = 64'sd3373259426;
  localparam longint HALF_PI_FIX30  = 64'sd1686629713;
  localparam longint TWO_PI_FIX30   = 64'sd6746518852;
  localparam longint ROT_GAIN_FIX30 = 64'sd652032874;
  localparam logic [15:0] STEP_RESET = 16'd3277;
  localparam logic [31:0] POS_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX    = 32'h8000_0000;
  localparam logic [31:0] ONE_FIX16  = 32'h0001_0000;
  // Quiet cycles before a time-step write: longer than one command item
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_ITEMS   = 63;

  localparam longint ARCTAN_FIX30 [0:29] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64,
    32, 16, 8, 4, 2
  };

  typedef enum logic [1:0] {
    EV_ITEM,
    EV_STEP_WRITE,
    EV_SETTLE
  } stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    logic        load;
    logic [31:0] x, y, h, v, w;
    logic        last;
    logic [15:0] ts;
  } stim_entry_t;

  typedef struct {
    logic [31:0] x, y, h;
    logic        last;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we = 1'b0;
  logic [TsW-1:0]      cfg_wdata = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                s_user = 1'b0;
  logic                s_last = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_last;

  // Stimulus still to be sent and poses still to be received
  stim_entry_t pose_stim_q[$];
  pose_t       expected_pose_q[$];

  // Integrator state of the predictor
  logic [31:0] pose_x = '0;
  logic [31:0] pose_y = '0;
  logic [31:0] pose_h = '0;
  logic [15:0] step_ts = STEP_RESET;

  int sent_cnt = 0;
  int seen_cnt = 0;
  int err_cnt = 0;
  int n_loads = 0;
  int n_steps = 0;
  int n_wraps = 0;
  int n_folds = 0;
  int n_ts_writes = 0;
  int burst_left = 0;
  int gap_left = 0;
  int settle_cnt = 0;

  unicycle_pose_predictor_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  // Generate the 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hold reset low at startup, then release it
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sine and cosine of a Q16.16 heading by shift-add rotation in Q2.30
  function automatic void rotate_heading(input longint hd, output longint c,
                                         output longint s);
    longint a, x, y, z, xs, ys;
    bit flip;
    a = hd * 16384;
    a = a % TWO_PI_FIX30;
    if (a > PI_FIX30) a -= TWO_PI_FIX30;
    if (a < -PI_FIX30) a += TWO_PI_FIX30;
    flip = 1'b0;
    if (a > HALF_PI_FIX30) begin
      a -= PI_FIX30;
      flip = 1'b1;
    end else if (a < -HALF_PI_FIX30) begin
      a += PI_FIX30;
      flip = 1'b1;
    end
    if (flip) n_folds++;
    x = ROT_GAIN_FIX30;
    y = 0;
    z = a;
    for (int i = 0; i < CordicIters; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z -= ARCTAN_FIX30[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z += ARCTAN_FIX30[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advance the stored pose by one transfer and return the new pose
  function automatic pose_t integrate_pose(input stim_entry_t e);
    longint hd, v, w, c, s, ts, dx, dy, dh;
    pose_t r;
    if (e.load) begin
      pose_x = e.x;
      pose_y = e.y;
      pose_h = e.h;
      n_loads++;
    end else begin
      hd = longint'($signed(pose_h));
      v = longint'($signed(e.v));
      w = longint'($signed(e.w));
      ts = longint'(step_ts);
      // one correction only; a heading far outside stays outside
      if (hd > PI_FIX16) begin
        hd -= TWO_PI_FIX16;
        n_wraps++;
      end
      if (hd < -PI_FIX16) begin
        hd += TWO_PI_FIX16;
        n_wraps++;
      end
      rotate_heading(hd, c, s);
      dx = (((v * c) >>> 30) * ts) >>> 16;
      dy = (((v * s) >>> 30) * ts) >>> 16;
      dh = (w * ts) >>> 16;
      pose_x = pose_x + dx[31:0];
      pose_y = pose_y + dy[31:0];
      pose_h = hd[31:0] + dh[31:0];
      n_steps++;
    end
    r.x = pose_x;
    r.y = pose_y;
    r.h = pose_h;
    r.last = e.last;
    return r;
  endfunction

  function automatic void push_item(input logic load, input logic [31:0] x, y, h, v, w,
                                    input logic last);
    stim_entry_t e;
    e.kind = EV_ITEM;
    e.load = load;
    e.x = x;
    e.y = y;
    e.h = h;
    e.v = v;
    e.w = w;
    e.last = last;
    e.ts = '0;
    pose_stim_q = {pose_stim_q, e};
  endfunction

  function automatic void push_marker(input stim_kind_e kind, input logic [15:0] ts);
    stim_entry_t e;
    e.kind = kind;
    e.load = 1'b0;
    e.x = '0;
    e.y = '0;
    e.h = '0;
    e.v = '0;
    e.w = '0;
    e.last = 1'b0;
    e.ts = ts;
    pose_stim_q = {pose_stim_q, e};
  endfunction

  // Load with junk command fields, then one command with junk init fields
  function automatic void push_load_step(input logic [31:0] h);
    push_item(1'b1, $urandom(), $urandom(), h, $urandom(), $urandom(), 1'b0);
    push_item(1'b0, $urandom(), $urandom(), $urandom(), ONE_FIX16, 32'd0, 1'b1);
  endfunction

  function automatic logic [31:0] signed_mag(input int unsigned mag);
    int val;
    val = int'(mag);
    if ($urandom_range(0, 1)) val = -val;
    return val;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return signed_mag($urandom_range(0, 20 * 65536));
  endfunction

  function automatic logic [31:0] rand_heading();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return signed_mag(32'(PI_FIX16 + $urandom_range(0, 4) - 2));
      2: return signed_mag(102944 + $urandom_range(0, 4) - 2);
      default: return signed_mag($urandom_range(0, 32'(2 * TWO_PI_FIX16)));
    endcase
  endfunction

  function automatic logic [31:0] rand_rate(input int unsigned span);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
      default: return signed_mag($urandom_range(0, span));
    endcase
  endfunction

  // One horizon: mostly load plus commands ending on tlast, sometimes broken
  function automatic int push_horizon();
    int n;
    bit noisy;
    n = $urandom_range(1, 12);
    noisy = ($urandom_range(0, 6) == 0);
    if (!noisy || $urandom_range(0, 1))
      push_item(1'b1, rand_coord(), rand_coord(), rand_heading(), $urandom(), $urandom(),
                noisy ? 1'($urandom_range(0, 1)) : 1'b0);
    for (int i = 0; i < n; i++) begin
      if (noisy)
        push_item(1'($urandom_range(0, 3) == 0), $urandom(), $urandom(), $urandom(),
                  rand_rate(4 * 65536), rand_rate(8 * 65536), 1'($urandom_range(0, 1)));
      else
        push_item(1'b0, $urandom(), $urandom(), $urandom(), rand_rate(3 * 65536),
                  rand_rate(2 * 65536), i == n - 1);
    end
    return n + 1;
  endfunction

  // Fill the stimulus: directed corners first, then random horizons per step size
  initial begin : build_stimulus
    logic [15:0] phase_ts [6];
    int cnt;
    phase_ts = '{16'hffff, 16'd1, 16'd0, 16'd0, STEP_RESET, 16'd0};

    push_item(1'b0, $urandom(), $urandom(), $urandom(), ONE_FIX16, 32'h0000_8000, 1'b0);
    push_item(1'b1, POS_MAX, NEG_MAX, 32'd0, $urandom(), $urandom(), 1'b0);
    push_item(1'b0, $urandom(), $urandom(), $urandom(), POS_MAX, POS_MAX, 1'b0);
    push_item(1'b0, $urandom(), $urandom(), $urandom(), NEG_MAX, NEG_MAX, 1'b1);
    // heading at and just past +-pi, at the word limits, and around +-pi/2
    push_load_step(32'd205887);
    push_load_step(32'd205888);
    push_load_step(-32'sd205887);
    push_load_step(-32'sd205888);
    push_load_step(POS_MAX);
    push_load_step(NEG_MAX);
    push_load_step(32'd102944);
    push_load_step(32'd102943);
    push_load_step(-32'sd102944);
    push_marker(EV_STEP_WRITE, 16'hffff);
    push_item(1'b0, $urandom(), $urandom(), $urandom(), POS_MAX, POS_MAX, 1'b1);
    push_marker(EV_STEP_WRITE, 16'd1);
    push_item(1'b0, $urandom(), $urandom(), $urandom(), NEG_MAX, NEG_MAX, 1'b1);

    foreach (phase_ts[p]) begin
      push_marker(EV_STEP_WRITE, (phase_ts[p] != 0) ? phase_ts[p]
                                                     : 16'($urandom_range(1, 65535)));
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        cnt += push_horizon();
        // let the block run dry at least once per phase
        if (cnt >= PHASE_ITEMS / 2 && cnt < PHASE_ITEMS / 2 + 13)
          push_marker(EV_SETTLE, 16'd0);
      end
    end
  end

  // Drive input transfers in bursts and time-step writes when idle
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic nvalid, nwe, take;
    stim_entry_t e;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      s_user <= 1'b0;
      s_last <= 1'b0;
      cfg_we <= 1'b0;
      cfg_wdata <= '0;
    end else begin
      nvalid = s_valid;
      nwe = 1'b0;
      take = 1'b0;
      if (s_valid && s_ready) begin
        nvalid = 1'b0;
        sent_cnt++;
      end
      if (sent_cnt == seen_cnt && !nvalid) settle_cnt++;
      else settle_cnt = 0;
      if (!nvalid && pose_stim_q.size() != 0) begin
        if (pose_stim_q[0].kind == EV_ITEM) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            e = pose_stim_q.pop_front();
            nvalid = 1'b1;
            take = 1'b1;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 15);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
          end
        end else if (settle_cnt >= SETTLE_CYCLES) begin
          e = pose_stim_q.pop_front();
          nwe = (e.kind == EV_STEP_WRITE);
          settle_cnt = 0;
        end
      end
      s_valid <= nvalid;
      cfg_we <= nwe;
      if (nwe) cfg_wdata <= e.ts;
      if (take) begin
        s_data <= {e.w, e.v, e.h, e.y, e.x};
        s_user <= e.load;
        s_last <= e.last;
      end
    end
  end

  // Stall the result stream in random modes, each held for a random stretch
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned mode, mode_left, stall;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (stall > 0) begin
        stall--;
      end else begin
        case (mode)
          1: if ($urandom_range(0, 2) == 0) stall = $urandom_range(1, 3);
          2: if ($urandom_range(0, 9) == 0) stall = $urandom_range(5, 40);
          3: if ($urandom_range(0, 1)) stall = 1;
          default: ;
        endcase
      end
      m_ready <= (stall == 0);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Check each result against the oldest prediction, then predict new transfers
  always @(posedge clk_i) begin : monitor
    pose_t exp_p;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        seen_cnt <= seen_cnt + 1;
        if (expected_pose_q.size() == 0) begin
          $error("result with no pending prediction: tdata %h", m_data);
          err_cnt++;
        end else begin
          exp_p = expected_pose_q.pop_front();
          compare_field("pred_x", exp_p.x, m_data[31:0]);
          compare_field("pred_y", exp_p.y, m_data[63:32]);
          compare_field("pred_heading", exp_p.h, m_data[95:64]);
          compare_field("last_out", 32'(exp_p.last), 32'(m_last));
        end
      end
      if (s_valid && s_ready)
        expected_pose_q = {expected_pose_q, integrate_pose('{EV_ITEM, s_user,
            s_data[31:0], s_data[63:32], s_data[95:64], s_data[127:96], s_data[159:128],
            s_last, 16'd0})};
      if (cfg_we) begin
        step_ts = cfg_wdata;
        n_ts_writes++;
      end
    end
  end

  // Finish once all stimulus is sent and every prediction has been matched
  initial begin : finish_run
    @(posedge rst_ni);
    while (pose_stim_q.size() != 0 || s_valid || expected_pose_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_pose_q.size() != 0) begin
      $error("%0d predicted poses never arrived", expected_pose_q.size());
      err_cnt++;
    end
    $display("Covered %0d pose loads and %0d command steps under %0d time-step writes.",
             n_loads, n_steps, n_ts_writes);
    $display("Heading wrapped %0d times, trig fold taken %0d times, %0d results checked.",
             n_wraps, n_folds, seen_cnt);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up well after the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $error("timeout: %0d transfers sent, %0d results seen", sent_cnt, seen_cnt);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/upp_pkg.sv
hw/rtl/upp_ctrl.sv
hw/rtl/upp_dp.sv
hw/rtl/unicycle_pose_predictor_core.sv
hw/rtl/upp_checker.sv
test/testbench.sv
